// ===== rtl/core/qsaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadrature steering angle filter package
// Shared widths, constants, codes and types of the steering angle filter.
// ----------------------------------------------------------------------------
package qsaf_pkg;

    // Field widths
    localparam int TICK_W  = 18;
    localparam int TPT_W   = 14;
    localparam int NOW_W   = 32;
    localparam int FUNC_W  = 3;
    localparam int ANGO_W  = 15;
    localparam int CFG_IDX_W = 1;

    // Datapath widths
    localparam int MAG_W   = TICK_W;       // |count - zero| stays below 2^18
    localparam int M90_W   = MAG_W + 7;    // magnitude times 90
    localparam int NUM_W   = M90_W + 10;   // magnitude times 92160 plus half divisor
    localparam int QUO_W   = 28;           // largest angle is below 2^28
    localparam int ANG_W   = 30;           // signed Q8 angle
    localparam int EMA_W   = 38;           // weighted sum before the shift

    // Limits and constants
    localparam int TickLimit       = 100000;
    localparam int CenterTimeoutMs = 10000;
    localparam int TptMin          = 100;
    localparam int TptMax          = 10000;
    localparam int TptDefault      = 1024;
    localparam int DegMul          = 90;   // 92160 = 90 * 1024
    localparam int JumpQ8          = 3840;
    localparam int RateQ8          = 2048;
    localparam int HystQ8          = 76;
    localparam int ClampQ8         = 13824;
    localparam int EmaA            = 46;
    localparam int EmaB            = 210;
    localparam int EmaRound        = 128;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_A_EDGE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INDEX   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CENTER  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_OFFSET  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TPT    = 1'd1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_START,
        ST_DIV,
        ST_NEG,
        ST_JUMP,
        ST_EMA1,
        ST_EMA2,
        ST_LIMIT,
        ST_COMMIT,
        ST_PUB
    } state_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/qsaf_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle; the numerator shifts out
// of the top of a shift register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module qsaf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [qsaf_pkg::NUM_W-1:0]    num,
    input  logic [qsaf_pkg::TPT_W-1:0]    den,
    output logic [qsaf_pkg::QUO_W-1:0]    quo,
    output qsaf_pkg::div_stat_t           stat
);
    import qsaf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] shift_reg;
    logic [TPT_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [TPT_W:0]   trial;
    logic             ge;

    // Trial subtraction of one digit.
    assign trial = {rem_reg, shift_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den});

    // Control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= num;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[NUM_W-2:0], ge};
            rem_reg   <= ge ? TPT_W'(trial - {1'b0, den}) : trial[TPT_W-1:0];
        end
    end

    assign quo       = shift_reg[QUO_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/quadrature_steering_angle_filter.sv =====
// ----------------------------------------------------------------------------
// Quadrature steering angle filter
// Counts encoder edges and turns the count into a filtered, clamped angle.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_      | in        | tuser: func; tdata: enc_a, enc_b, now_ms, offset_value
//  m_      | out       | tdata: tick_count, angle_q8, is_centered, is_valid, at_limit
//  cfg_    | in        | cfg_index, cfg_data (always ready)
//
// One word is worked at a time. An update tick with steering enabled runs
// through the multiply, add, bit-serial divide, jump, filter, limit and commit
// states; every other word goes straight to publish. Reset loads the register
// defaults and clears the sequencer and filter state. A stalled result holds s_tready low.
// ----------------------------------------------------------------------------
module quadrature_steering_angle_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] enc_a, [1] enc_b, [33:2] now_ms, [51:34] offset_value
    input  logic [55:0]                       s_tdata,
    // [2:0] func
    input  logic [qsaf_pkg::FUNC_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [17:0] tick_count, [32:18] angle_q8, [33] is_centered, [34] is_valid,
    // [35] at_limit
    output logic [39:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qsaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qsaf_pkg::TPT_W-1:0]        cfg_data
);
    import qsaf_pkg::*;

    localparam logic signed [TICK_W-1:0] TICK_HI = TICK_W'(TickLimit);
    localparam logic signed [TICK_W-1:0] TICK_LO = -TICK_W'(TickLimit);
    localparam logic signed [EMA_W-1:0]  EMA_A_C = EMA_W'(EmaA);
    localparam logic signed [EMA_W-1:0]  EMA_B_C = EMA_W'(EmaB);

    state_t state_reg, state_next;

    // Configuration
    logic             enable_reg;
    logic [TPT_W-1:0] tpt_reg;

    // Filter state
    logic signed [TICK_W-1:0] tick_reg;
    logic signed [TICK_W-1:0] zp_reg;
    logic signed [ANG_W-1:0]  filt_reg;
    logic signed [ANG_W-1:0]  lg_reg;
    logic                     primed_reg;
    logic                     idx_reg;
    logic                     cent_reg;
    logic                     started_reg;
    logic [NOW_W-1:0]         start_ms_reg;
    logic signed [ANGO_W-1:0] pub_angle_reg;
    logic                     pub_valid_reg;

    // Working registers
    logic [NOW_W-1:0]         now_reg;
    logic                     neg_reg;
    logic [M90_W-1:0]         m90_reg;
    logic [NUM_W-1:0]         num_reg;
    logic signed [ANG_W-1:0]  ang_reg;
    logic signed [ANG_W-1:0]  raw_reg;
    logic signed [EMA_W-1:0]  pa_reg;
    logic signed [EMA_W-1:0]  pb_reg;
    logic signed [ANG_W-1:0]  f_reg;

    // Output register
    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    logic                     accept;
    logic [FUNC_W-1:0]        func;
    logic                     enc_a;
    logic                     enc_b;
    logic [NOW_W-1:0]         now_ms;
    logic signed [TICK_W-1:0] offset_value;
    logic                     div_start;
    logic [QUO_W-1:0]         div_quo;
    div_stat_t                div_stat;

    logic signed [TICK_W:0]   diff;
    logic [TICK_W:0]          mag;
    logic signed [ANG_W-1:0]  lg_e;
    logic signed [ANG_W-1:0]  filt_e;
    logic signed [ANG_W:0]    jump_d;
    logic signed [EMA_W-1:0]  ema_sum;
    logic signed [ANG_W:0]    lim_lo;
    logic signed [ANG_W:0]    lim_hi;
    logic signed [ANG_W:0]    f_ext;
    logic signed [ANG_W:0]    hyst_d;
    logic signed [ANG_W-1:0]  f_fin;
    logic signed [TICK_W-1:0] tick_sat;
    logic signed [TICK_W-1:0] tc_out;
    logic [NOW_W-1:0]         elapsed;

    assign func         = s_tuser;
    assign enc_a        = s_tdata[0];
    assign enc_b        = s_tdata[1];
    assign now_ms       = s_tdata[33:2];
    assign offset_value = s_tdata[51:34];

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (func == FUNC_UPDATE && enable_reg) ? ST_MUL : ST_PUB;
                end
            end
            ST_MUL:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_START;
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_NEG;
                end
            end
            ST_NEG:    state_next = ST_JUMP;
            ST_JUMP:   state_next = ST_EMA1;
            ST_EMA1:   state_next = ST_EMA2;
            ST_EMA2:   state_next = ST_LIMIT;
            ST_LIMIT:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_PUB;
            ST_PUB:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            tpt_reg    <= TPT_W'(TptDefault);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_TPT: begin
                    if (cfg_data < TPT_W'(TptMin) || cfg_data > TPT_W'(TptMax)) begin
                        tpt_reg <= TPT_W'(TptDefault);
                    end else begin
                        tpt_reg <= cfg_data;
                    end
                end
                default: ;
            endcase
        end
    end

    // Bit-serial divide by ticks per turn.
    qsaf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (tpt_reg),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    // Combinational helpers.
    assign diff     = {tick_reg[TICK_W-1], tick_reg} - {zp_reg[TICK_W-1], zp_reg};
    assign mag      = diff[TICK_W] ? (TICK_W+1)'(-diff) : diff;
    assign lg_e     = primed_reg ? lg_reg : ang_reg;
    assign filt_e   = primed_reg ? filt_reg : ang_reg;
    assign jump_d   = {ang_reg[ANG_W-1], ang_reg} - {lg_e[ANG_W-1], lg_e};
    assign ema_sum  = pa_reg + pb_reg + EMA_W'(EmaRound);
    assign lim_lo   = {ang_reg[ANG_W-1], ang_reg} - (ANG_W+1)'(RateQ8);
    assign lim_hi   = {ang_reg[ANG_W-1], ang_reg} + (ANG_W+1)'(RateQ8);
    assign f_ext    = {f_reg[ANG_W-1], f_reg};
    assign hyst_d   = f_ext - {ang_reg[ANG_W-1], ang_reg};
    assign f_fin    = (hyst_d <= (ANG_W+1)'(HystQ8) && hyst_d >= -(ANG_W+1)'(HystQ8))
                      ? ang_reg : f_reg;
    assign elapsed  = now_reg - start_ms_reg;
    assign tick_sat = (enc_a == enc_b)
                      ? ((tick_reg == TICK_HI) ? TICK_HI : tick_reg + 1'b1)
                      : ((tick_reg == TICK_LO) ? TICK_LO : tick_reg - 1'b1);
    assign tc_out   = enable_reg ? tick_reg : '0;

    // Angle datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE:  now_reg <= now_ms;
            ST_MUL: begin
                neg_reg <= diff[TICK_W];
                m90_reg <= M90_W'(mag[MAG_W-1:0]) * M90_W'(DegMul);
            end
            ST_ADD:   num_reg <= {m90_reg, 10'b0} + NUM_W'(tpt_reg >> 1);
            ST_NEG: begin
                ang_reg <= neg_reg ? -ANG_W'(div_quo) : ANG_W'(div_quo);
            end
            ST_JUMP: begin
                if (jump_d > (ANG_W+1)'(JumpQ8) || jump_d < -(ANG_W+1)'(JumpQ8)) begin
                    raw_reg <= lg_e;
                end else begin
                    raw_reg <= ang_reg;
                end
            end
            ST_EMA1: begin
                pa_reg <= EMA_W'(raw_reg) * EMA_A_C;
                pb_reg <= EMA_W'(filt_reg) * EMA_B_C;
            end
            ST_EMA2:  f_reg <= ANG_W'(ema_sum >>> 8);
            ST_LIMIT: begin
                if (f_ext < lim_lo) begin
                    f_reg <= ANG_W'(lim_lo);
                end else if (f_ext > lim_hi) begin
                    f_reg <= ANG_W'(lim_hi);
                end
            end
            default: ;
        endcase
    end

    // Counter, zero point, centering and published values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            zp_reg        <= '0;
            filt_reg      <= '0;
            lg_reg        <= '0;
            primed_reg    <= 1'b0;
            idx_reg       <= 1'b0;
            cent_reg      <= 1'b0;
            started_reg   <= 1'b0;
            start_ms_reg  <= '0;
            pub_angle_reg <= '0;
            pub_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                case (func)
                    FUNC_A_EDGE: tick_reg <= tick_sat;
                    FUNC_INDEX:  idx_reg  <= 1'b1;
                    FUNC_UPDATE: begin
                        if (!enable_reg) begin
                            pub_angle_reg <= '0;
                            pub_valid_reg <= 1'b0;
                            cent_reg      <= 1'b0;
                            started_reg   <= 1'b0;
                            start_ms_reg  <= '0;
                        end
                    end
                    FUNC_CENTER: begin
                        if (!cent_reg) begin
                            zp_reg   <= tick_reg;
                            cent_reg <= 1'b1;
                            if (idx_reg) begin
                                idx_reg      <= 1'b0;
                                started_reg  <= 1'b0;
                                start_ms_reg <= '0;
                            end
                        end
                    end
                    FUNC_OFFSET: begin
                        zp_reg   <= offset_value;
                        cent_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            // Prime on the first update, then track the last accepted angle.
            if (state_reg == ST_JUMP) begin
                primed_reg <= 1'b1;
                filt_reg   <= filt_e;
                if (jump_d > (ANG_W+1)'(JumpQ8) || jump_d < -(ANG_W+1)'(JumpQ8)) begin
                    lg_reg <= lg_e;
                end else begin
                    lg_reg <= ang_reg;
                end
            end
            // Filter result, output clamp and centering decisions.
            if (state_reg == ST_COMMIT) begin
                filt_reg <= f_fin;
                if (f_fin > ANG_W'(ClampQ8)) begin
                    pub_angle_reg <= ANGO_W'(ClampQ8);
                end else if (f_fin < -ANG_W'(ClampQ8)) begin
                    pub_angle_reg <= -ANGO_W'(ClampQ8);
                end else begin
                    pub_angle_reg <= ANGO_W'(f_fin);
                end
                if (!cent_reg && !idx_reg) begin
                    if (!started_reg) begin
                        started_reg  <= 1'b1;
                        start_ms_reg <= now_reg;
                    end else if (elapsed > NOW_W'(CenterTimeoutMs)) begin
                        zp_reg       <= tick_reg;
                        cent_reg     <= 1'b1;
                        started_reg  <= 1'b0;
                        start_ms_reg <= '0;
                    end
                    pub_valid_reg <= 1'b0;
                end else begin
                    pub_valid_reg <= 1'b1;
                end
                if (idx_reg && !cent_reg) begin
                    zp_reg       <= tick_reg;
                    cent_reg     <= 1'b1;
                    idx_reg      <= 1'b0;
                    started_reg  <= 1'b0;
                    start_ms_reg <= '0;
                end
            end
        end
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_PUB) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUB) begin
            m_data_reg <= {4'b0,
                           (tc_out == TICK_HI) || (tc_out == TICK_LO),
                           pub_valid_reg,
                           cent_reg,
                           pub_angle_reg,
                           tc_out};
        end
    end

    // Assertions
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input taken outside the idle state");

    a_tick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_reg <= TICK_HI) && (tick_reg >= TICK_LO))
        else $error("tick counter beyond its saturation limit");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide state");

    a_pub_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUB) |-> (!m_valid_reg || m_tready))
        else $error("result word overwritten before it was taken");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Steering angle filter testbench
// Drives encoder edges, index pulses, update ticks and zero-point commands
// into the filter with random gaps and stalls. A scoreboard predicts every
// result word and compares it field by field. Register writes happen only
// while the block is idle. The register writes cover the extremes of both
// registers, including out-of-range turn counts.
// ----------------------------------------------------------------------------
import qsaf_pkg::*;

typedef struct {
    int tick_count;
    int angle_q8;
    bit is_centered;
    bit is_valid;
    bit at_limit;
} steer_word_t;

class steer_scoreboard;
    bit          enable;
    int          turn_ticks;
    int          tick_cnt;
    int          zero_pt;
    longint      filt_ang;
    longint      good_ang;
    bit          primed;
    bit          index_flag;
    bit          centered;
    bit [31:0]   timer_start;
    bit          timer_run;
    int          pub_ang;
    bit          pub_ok;
    steer_word_t pending[$];
    int          errors;

    function new();
        enable     = 1'b1;
        turn_ticks = TptDefault;
        errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TPT_W-1:0] val);
        if (idx == REG_ENABLE) begin
            enable = val[0];
        end else begin
            turn_ticks = (val < TptMin || val > TptMax) ? TptDefault : int'(val);
        end
    endfunction

    // Count relative to the zero point, in 1/256 degree, rounded half away.
    function longint to_q8(int t);
        longint diff;
        longint mag;
        diff = longint'(t) - longint'(zero_pt);
        mag  = (diff < 0) ? -diff : diff;
        mag  = (mag * 92160 + turn_ticks / 2) / turn_ticks;
        return (diff < 0) ? -mag : mag;
    endfunction

    function void run_update(bit [31:0] now);
        longint ang;
        longint raw;
        longint f;
        bit [31:0] waited;
        if (!enable) begin
            pub_ang     = 0;
            pub_ok      = 1'b0;
            centered    = 1'b0;
            timer_run   = 1'b0;
            timer_start = '0;
            return;
        end
        ang = to_q8(tick_cnt);
        raw = ang;
        if (!primed) begin
            filt_ang = raw;
            good_ang = raw;
            primed   = 1'b1;
        end
        // Large jumps are treated as interference and replaced.
        if (raw - good_ang > JumpQ8 || raw - good_ang < -JumpQ8) raw = good_ang;
        else good_ang = raw;
        f = (EmaA * raw + EmaB * filt_ang + EmaRound) >>> 8;
        if (f > ang + RateQ8) f = ang + RateQ8;
        if (f < ang - RateQ8) f = ang - RateQ8;
        if (f - ang <= HystQ8 && f - ang >= -HystQ8) f = ang;
        filt_ang = f;
        pub_ang  = (f > ClampQ8) ? ClampQ8 : ((f < -ClampQ8) ? -ClampQ8 : int'(f));
        // Centering by timeout when no zero point is known yet.
        if (!centered && !index_flag) begin
            if (!timer_run) begin
                timer_run   = 1'b1;
                timer_start = now;
            end else begin
                waited = now - timer_start;
                if (waited > CenterTimeoutMs) begin
                    zero_pt     = tick_cnt;
                    centered    = 1'b1;
                    timer_run   = 1'b0;
                    timer_start = '0;
                end
            end
            pub_ok = 1'b0;
        end else begin
            pub_ok = 1'b1;
        end
        if (index_flag && !centered) begin
            zero_pt     = tick_cnt;
            centered    = 1'b1;
            index_flag  = 1'b0;
            timer_run   = 1'b0;
            timer_start = '0;
        end
    endfunction

    // Note an accepted input word and queue the result it causes.
    function void note_input(logic [FUNC_W-1:0] fn, bit a, bit b, bit [31:0] now,
                             logic signed [17:0] offs);
        steer_word_t w;
        case (fn)
            FUNC_A_EDGE: begin
                tick_cnt += (a == b) ? 1 : -1;
                if (tick_cnt > TickLimit) tick_cnt = TickLimit;
                if (tick_cnt < -TickLimit) tick_cnt = -TickLimit;
            end
            FUNC_INDEX: index_flag = 1'b1;
            FUNC_UPDATE: run_update(now);
            FUNC_CENTER: begin
                if (!centered) begin
                    zero_pt  = tick_cnt;
                    centered = 1'b1;
                    if (index_flag) begin
                        index_flag  = 1'b0;
                        timer_run   = 1'b0;
                        timer_start = '0;
                    end
                end
            end
            FUNC_OFFSET: begin
                zero_pt  = offs;
                centered = 1'b1;
            end
            default: ;
        endcase
        w.tick_count  = enable ? tick_cnt : 0;
        w.angle_q8    = pub_ang;
        w.is_centered = centered;
        w.is_valid    = pub_ok;
        w.at_limit    = (w.tick_count >= TickLimit || w.tick_count <= -TickLimit);
        pending.push_back(w);
    endfunction

    function void check_result(logic [39:0] d);
        steer_word_t w;
        int tc;
        int an;
        if (pending.size() == 0) begin
            $error("result word with nothing expected: %h", d);
            errors++;
            return;
        end
        w  = pending.pop_front();
        tc = int'($signed(d[17:0]));
        an = int'($signed(d[32:18]));
        if (tc != w.tick_count) begin
            $error("tick_count: expected %0d, got %0d", w.tick_count, tc);
            errors++;
        end
        if (an != w.angle_q8) begin
            $error("angle_q8: expected %0d, got %0d", w.angle_q8, an);
            errors++;
        end
        if (d[33] != w.is_centered) begin
            $error("is_centered: expected %0d, got %0d", w.is_centered, d[33]);
            errors++;
        end
        if (d[34] != w.is_valid) begin
            $error("is_valid: expected %0d, got %0d", w.is_valid, d[34]);
            errors++;
        end
        if (d[35] != w.at_limit) begin
            $error("at_limit: expected %0d, got %0d", w.at_limit, d[35]);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CycleLimit = 3000000;
    localparam int DrainWait  = 80;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [55:0]          s_tdata;
    logic [FUNC_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TPT_W-1:0]     cfg_data;

    steer_scoreboard sb;
    bit        gaps_on;
    int        cycles;
    bit [31:0] clock_ms;
    int        drift;

    quadrature_steering_angle_filter dut (.*);

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Result side: random stalls before each word, then check it.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            sb.check_result(m_tdata);
        end
    end

    // Send one input word, with an optional random gap in front.
    task automatic send_word(logic [FUNC_W-1:0] fn, bit a, bit b, bit [31:0] now,
                             logic signed [17:0] offs);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {4'b0, offs, now, b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(fn, a, b, now, offs);
    endtask

    // Drain all results, then write one register.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TPT_W-1:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic update_at(bit [31:0] now);
        send_word(FUNC_UPDATE, 1'b0, 1'b0, now, '0);
    endtask

    // Mostly edge runs and updates with advancing time, plus commands and noise.
    task automatic random_words(int count);
        int pick;
        logic signed [17:0] offs;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) drift = -drift;
            pick = $urandom_range(0, 99);
            offs = 18'($urandom_range(0, 200000) - 100000);
            if (pick < 50) begin
                bit a;
                a = 1'($urandom_range(0, 1));
                // Mostly follow the current direction; when drifting upward, sometimes jitter back.
                if ($urandom_range(0, 4) == 0) send_word(FUNC_A_EDGE, a, ~a, $urandom, offs);
                else if (drift > 0) send_word(FUNC_A_EDGE, a, a, $urandom, offs);
                else send_word(FUNC_A_EDGE, a, ~a, $urandom, offs);
            end else if (pick < 78) begin
                if ($urandom_range(0, 15) == 0) clock_ms += $urandom;
                else clock_ms += $urandom_range(0, 4000);
                send_word(FUNC_UPDATE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          clock_ms, offs);
            end else if (pick < 84) begin
                send_word(FUNC_INDEX, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom, offs);
            end else if (pick < 89) begin
                send_word(FUNC_CENTER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom, offs);
            end else if (pick < 94) begin
                send_word(FUNC_OFFSET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom, offs);
            end else begin
                send_word(FUNC_W'($urandom_range(5, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom, offs);
            end
        end
    endtask

    initial begin
        logic [TPT_W-1:0] turn_set[7];
        sb        = new();
        gaps_on   = 1'b1;
        clock_ms  = 0;
        drift     = 1;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ENABLE;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every edge direction, timeout centering, time extremes.
        send_word(FUNC_A_EDGE, 1'b0, 1'b0, 32'hFFFF_FFFF, 18'sd0);
        send_word(FUNC_A_EDGE, 1'b1, 1'b1, 32'd0, 18'sd0);
        send_word(FUNC_A_EDGE, 1'b0, 1'b1, 32'd0, 18'sd0);
        send_word(FUNC_A_EDGE, 1'b1, 1'b0, 32'd0, 18'sd0);
        send_word(FUNC_A_EDGE, 1'b1, 1'b1, 32'd0, 18'sd0);
        update_at(32'd0);
        update_at(32'd5000);
        update_at(32'd10000);
        update_at(32'd10001);
        send_word(FUNC_CENTER, 1'b0, 1'b0, 32'd0, 18'sd0);
        send_word(FUNC_INDEX, 1'b0, 1'b0, 32'd0, 18'sd0);
        update_at(32'hFFFF_FFFF);
        send_word(FUNC_OFFSET, 1'b0, 1'b0, 32'd0, -18'sd100000);
        update_at(32'd20000);
        send_word(FUNC_OFFSET, 1'b0, 1'b0, 32'd0, 18'sd100000);
        update_at(32'd20001);
        send_word(3'd5, 1'b1, 1'b1, 32'd0, 18'sd0);
        send_word(3'd6, 1'b0, 1'b1, 32'd0, 18'sd0);
        send_word(3'd7, 1'b1, 1'b0, 32'd0, 18'sd0);

        // Disabled: neutral outputs, then center and index from uncentered.
        write_reg(REG_ENABLE, TPT_W'(1));
        write_reg(REG_ENABLE, TPT_W'(0));
        send_word(FUNC_A_EDGE, 1'b1, 1'b1, 32'd0, 18'sd0);
        update_at(32'd30000);
        write_reg(REG_ENABLE, TPT_W'(1));
        send_word(FUNC_INDEX, 1'b0, 1'b0, 32'd0, 18'sd0);
        send_word(FUNC_CENTER, 1'b0, 1'b0, 32'd0, 18'sd0);
        update_at(32'd30001);

        // Random phases across turn counts, out-of-range ones included.
        turn_set = '{14'd100, 14'd10000, 14'd0, 14'd16383, 14'd357, 14'd99, 14'd10001};
        foreach (turn_set[k]) begin
            write_reg(REG_TPT, turn_set[k]);
            if (k == 3) write_reg(REG_ENABLE, TPT_W'(0));
            if (k == 4) write_reg(REG_ENABLE, TPT_W'(1));
            random_words(180);
        end

        // Set a turn count of 100 and the drift downward for a final mixed phase.
        write_reg(REG_TPT, TPT_W'(100));
        drift = -1;
        random_words(100);

        // Drain and report.
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/qsaf_pkg.sv
rtl/core/qsaf_div.sv
rtl/core/quadrature_steering_angle_filter.sv
tb/testbench.sv
